FILE: hdl/sliding_window_first_negative_core_macros.svh
// assertion macros for the sliding window first negative block
// used by the checker module; needs clk and arst_n in scope
`ifndef SLIDING_WINDOW_FIRST_NEGATIVE_CORE_MACROS_SVH
`define SLIDING_WINDOW_FIRST_NEGATIVE_CORE_MACROS_SVH

// same-cycle implication
`define SWFN_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWFN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/swfn_pkg.sv
// shared types and constants for the sliding window first negative block
// no dependencies
package swfn_pkg;

	localparam int SAMPLE_W = 32;
	localparam int CFG_W    = 7;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [SAMPLE_W-1:0] sample;
	} step_t;

	typedef struct packed {
		logic                produce;
		logic [SAMPLE_W-1:0] value;
	} result_t;

endpackage

FILE: hdl/swfn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module swfn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/swfn_engine.sv
// window and negative queue state, one step per cycle while step.valid is high
// depends on swfn_pkg and swfn_ram
module swfn_engine #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic [swfn_pkg::CFG_W-1:0]  window_size,
	input  swfn_pkg::step_t             step,
	output swfn_pkg::result_t           res
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int KW = $clog2(WINDOW_MAX + 1);
	localparam int CW = ((KW > swfn_pkg::CFG_W) ? KW : swfn_pkg::CFG_W) + 1;
	localparam int LW = AW + 2;

	logic [AW-1:0] head_q, tail_q, hp_q;
	logic [KW-1:0] qcnt_q, fill_q;

	logic [AW-1:0] head_n, tail_n, hp_n;
	logic [KW-1:0] qcnt_n, fill_n;

	logic [KW-1:0] k_eff;
	logic [CW-1:0] ws_w;
	logic          neg, push, pop, produce, leave_neg;
	logic [KW-1:0] fill_inc, cnt_push;
	logic [LW-1:0] lsum;

	logic [swfn_pkg::SAMPLE_W-1:0] q_rdata, q_front, front;
	logic [AW-1:0]                 q_ra, h_ra;
	logic                          h_rdata, h_front;
	logic                          q_we;

	logic                          qcoll_q, hcoll_q, hbyp_q;
	logic [swfn_pkg::SAMPLE_W-1:0] qbyp_q;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(WINDOW_MAX - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	always_comb begin
		ws_w = CW'(window_size);
		if (window_size == '0) begin
			k_eff = KW'(1);
		end else if (ws_w > CW'(WINDOW_MAX)) begin
			k_eff = KW'(WINDOW_MAX);
		end else begin
			k_eff = KW'(ws_w);
		end
	end

	assign q_front = qcoll_q ? qbyp_q : q_rdata;
	assign h_front = hcoll_q ? hbyp_q : h_rdata;

	always_comb begin
		neg       = step.sample[swfn_pkg::SAMPLE_W-1];
		push      = neg && (qcnt_q != KW'(WINDOW_MAX));
		cnt_push  = qcnt_q + KW'(push);
		fill_inc  = fill_q + KW'(1);
		produce   = (fill_inc >= k_eff);
		leave_neg = (k_eff == KW'(1)) ? neg : h_front;
		pop       = produce && leave_neg && (cnt_push != '0);

		if (qcnt_q != '0) begin
			front = q_front;
		end else if (neg) begin
			front = step.sample;
		end else begin
			front = '0;
		end

		head_n = head_q;
		tail_n = tail_q;
		hp_n   = hp_q;
		qcnt_n = qcnt_q;
		fill_n = fill_q;
		if (clear || (step.valid && step.last)) begin
			head_n = '0;
			tail_n = '0;
			hp_n   = '0;
			qcnt_n = '0;
			fill_n = '0;
		end else if (step.valid) begin
			tail_n = push ? ptr_inc(tail_q) : tail_q;
			head_n = pop ? ptr_inc(head_q) : head_q;
			qcnt_n = cnt_push - KW'(pop);
			fill_n = produce ? (k_eff - KW'(1)) : fill_inc;
			hp_n   = ptr_inc(hp_q);
		end

		lsum = LW'(hp_n) + LW'(WINDOW_MAX) - (LW'(k_eff) - LW'(1));
		if (lsum >= LW'(WINDOW_MAX)) begin
			lsum = lsum - LW'(WINDOW_MAX);
		end
	end

	assign q_we = step.valid && push;
	assign q_ra = head_n;
	assign h_ra = lsum[AW-1:0];

	assign res.produce = step.valid && produce;
	assign res.value   = front;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			hp_q    <= '0;
			qcnt_q  <= '0;
			fill_q  <= '0;
			qcoll_q <= 1'b0;
			hcoll_q <= 1'b0;
		end else begin
			head_q  <= head_n;
			tail_q  <= tail_n;
			hp_q    <= hp_n;
			qcnt_q  <= qcnt_n;
			fill_q  <= fill_n;
			qcoll_q <= q_we && (tail_q == q_ra);
			hcoll_q <= step.valid && (hp_q == h_ra);
		end
	end

	always_ff @(posedge clk) begin
		qbyp_q <= step.sample;
		hbyp_q <= neg;
	end

	swfn_ram #(
		.WIDTH (swfn_pkg::SAMPLE_W),
		.DEPTH (WINDOW_MAX)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (step.sample),
		.raddr (q_ra),
		.rdata (q_rdata)
	);

	swfn_ram #(
		.WIDTH (1),
		.DEPTH (WINDOW_MAX)
	) u_sign_ram (
		.clk   (clk),
		.we    (step.valid),
		.waddr (hp_q),
		.wdata (neg),
		.raddr (h_ra),
		.rdata (h_rdata)
	);

endmodule

FILE: hdl/sliding_window_first_negative_core.sv
// top level of the sliding window first negative block
// depends on swfn_pkg and swfn_engine
//
// usage:
// samples enter on the in channel (sample, last_sample) with in_valid/in_ready.
// once window_size samples are present, every sample gives one transfer on
// the out channel: the oldest negative sample of the window, or zero if none.
// earlier samples of a sequence give no transfer.
// the sample flagged last_sample clears the window after its own result.
// window_size is written on the cfg channel (cfg_valid/cfg_ready) only while
// the block is idle; a write clears the window. values 0 and above WINDOW_MAX
// act as 1 and WINDOW_MAX.
// out_valid rises once the sample has passed the input register and then the
// result register. throughput: one sample per cycle while the receiver does not
// stall, set by the window step between the input and the result register.
// if the receiver stalls, the result is held and one more sample may wait
// in the input register before in_ready drops.
// reset: window empty, window_size 1, both channels empty.
module sliding_window_first_negative_core #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [swfn_pkg::SAMPLE_W-1:0] sample,
	input  logic                                last_sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [swfn_pkg::SAMPLE_W-1:0] first_negative,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swfn_pkg::CFG_W-1:0]          window_size
);

	logic                          valid_s1, last_s1;
	logic [swfn_pkg::SAMPLE_W-1:0] sample_s1;
	logic                          out_valid_q;
	logic [swfn_pkg::SAMPLE_W-1:0] result_q;
	logic [swfn_pkg::CFG_W-1:0]    window_size_q;
	logic                          adv, cfg_wr;
	swfn_pkg::step_t               step;
	swfn_pkg::result_t             res;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = !valid_s1 && !out_valid_q;
	assign cfg_wr    = cfg_valid && cfg_ready;

	assign step.valid  = adv;
	assign step.last   = last_s1;
	assign step.sample = sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			out_valid_q   <= 1'b0;
			window_size_q <= swfn_pkg::CFG_W'(1);
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv && res.produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				window_size_q <= window_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			last_s1   <= last_sample;
		end
		if (adv && res.produce) begin
			result_q <= res.value;
		end
	end

	swfn_engine #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.clear       (cfg_wr),
		.window_size (window_size_q),
		.step        (step),
		.res         (res)
	);

	assign out_valid      = out_valid_q;
	assign first_negative = result_q;

endmodule

FILE: hdl/swfn_checker.sv
// port-level checks for the sliding window first negative block
// depends on swfn_pkg and the macros header; bound to the top level
`include "sliding_window_first_negative_core_macros.svh"

module swfn_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [swfn_pkg::SAMPLE_W-1:0] first_negative,
	input logic                                cfg_ready
);

	logic stall, neg_or_zero;

	assign stall       = out_valid && !out_ready;
	assign neg_or_zero = first_negative[swfn_pkg::SAMPLE_W-1] || (first_negative == '0);

	`SWFN_ASSERT_NEXT(a_out_hold, stall, out_valid && $stable(first_negative), "stalled result changed")
	`SWFN_ASSERT_IMPLY(a_neg_or_zero, out_valid, neg_or_zero, "result neither negative nor zero")
	`SWFN_ASSERT_IMPLY(a_cfg_idle, cfg_ready, !out_valid, "config open while a result waits")
	`SWFN_ASSERT_IMPLY(a_in_open, !out_valid, in_ready, "input blocked with empty output")

endmodule

bind sliding_window_first_negative_core swfn_checker u_swfn_checker (.*);
